@@ rtl/bhsrp_pkg.sv @@
// ----------------------------------------------------------------------------
// Bucketed hash set package
// Action codes and the sequencer state type shared by the core.
// ----------------------------------------------------------------------------
package bhsrp_pkg;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_PICK   = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [13:0] {
		ST_CLEAR  = 14'b00000000000001,
		ST_IDLE   = 14'b00000000000010,
		ST_SRD    = 14'b00000000000100,
		ST_SCAN   = 14'b00000000001000,
		ST_SHRD   = 14'b00000000010000,
		ST_SHWR   = 14'b00000000100000,
		ST_LRD    = 14'b00000001000000,
		ST_LCMP   = 14'b00000010000000,
		ST_DIV    = 14'b00000100000000,
		ST_PLRD   = 14'b00001000000000,
		ST_PSRD   = 14'b00010000000000,
		ST_PSWT   = 14'b00100000000000,
		ST_OUT    = 14'b01000000000000,
		ST_LWT    = 14'b10000000000000
	} state_t;

endpackage

@@ rtl/bucketed_hash_set_random_pick_core.sv @@
// ----------------------------------------------------------------------------
// Bucketed hash set with random pick
// Signed 32-bit set in fixed-size buckets, with an ordered list of nonempty
// buckets for a random pick.
// ----------------------------------------------------------------------------
// After reset the block clears its slot memory, one slot per cycle, and takes
// no beat until done. One item at a time is processed by a sequencer around a
// single slot memory with one read and one write port and one compare unit:
// insert and remove read the bucket one slot at a time (a read state and a scan
// state per slot, after the state that takes the beat and before the one that
// raises the result), a remove shifts the later slots down with a read state
// and a write state per slot and then checks slot 0 again, and a remove that
// empties a bucket compacts the bucket list with a read state and a compare
// state per list entry. One restoring divider, one bit per cycle, serves both
// reductions: a random pick reduces random_word modulo the list count and then
// reads the list and the slot, and when NUM_BUCKETS is not a power of two an
// insert or remove first reduces the magnitude modulo NUM_BUCKETS. The result
// beat sits in an output register, and no new beat is taken until that result has been taken.
module bucketed_hash_set_random_pick_core #(
	parameter int NUM_BUCKETS  = 1024,
	parameter int BUCKET_SLOTS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic signed [31:0] value,
	input  logic [30:0]        random_word,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               success,
	output logic               bucket_full,
	output logic signed [31:0] picked_value
);

	localparam int BW   = $clog2(NUM_BUCKETS);
	localparam int SW   = $clog2(BUCKET_SLOTS);
	localparam int SCW  = $clog2(BUCKET_SLOTS + 1);
	localparam int DEP  = NUM_BUCKETS * BUCKET_SLOTS;
	localparam int AW   = $clog2(DEP);
	localparam int CW   = $clog2(NUM_BUCKETS + 1);
	localparam int DVW  = 32;
	localparam bit BKT_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);

	bhsrp_pkg::state_t state_q;

	logic [31:0] slot_mem [DEP];
	logic [BW-1:0] list_mem [NUM_BUCKETS];

	logic [31:0]     slot_rd_q;
	logic [BW-1:0]   list_rd_q;
	logic [AW-1:0]   clr_q;
	logic [1:0]      act_q;
	logic [31:0]     val_q;
	logic [BW-1:0]   bkt_q;
	logic [SCW-1:0]  idx_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   lr_q;
	logic [CW-1:0]   lw_q;
	logic            zero_q;
	logic [DVW-1:0]  rem_q;
	logic [DVW-1:0]  quo_q;
	logic [4:0]      dbit_q;
	logic            succ_q;
	logic            full_q;
	logic [31:0]     pick_q;
	logic            ovalid_q;

	logic            slot_we;
	logic [AW-1:0]   slot_wa;
	logic [31:0]     slot_wd;
	logic [AW-1:0]   slot_ra;
	logic            list_we;
	logic [BW-1:0]   list_wa;
	logic [BW-1:0]   list_wd;
	logic [BW-1:0]   list_ra;
	logic [31:0]     mag;
	logic [AW-1:0]   base;
	logic [CW-1:0]   dvs;
	logic [DVW:0]    trial;
	logic [DVW-1:0]  rem_nx;

	assign in_stall     = (state_q != bhsrp_pkg::ST_IDLE) || ovalid_q;
	assign out_valid    = ovalid_q;
	assign success      = succ_q;
	assign bucket_full  = full_q;
	assign picked_value = pick_q;

	assign mag  = value[31] ? (~value + 32'd1) : value;
	assign base = AW'(bkt_q) * AW'(BUCKET_SLOTS);

	// The divider reduces modulo the list count for a pick, else modulo NUM_BUCKETS.
	assign dvs = (act_q == bhsrp_pkg::ACT_PICK) ? cnt_q : CW'(NUM_BUCKETS);

	// Restoring division step: shift in the next bit of the dividend.
	assign trial  = {rem_q, quo_q[DVW-1]} - {{(DVW+1-CW){1'b0}}, dvs};
	assign rem_nx = trial[DVW] ? {rem_q[DVW-2:0], quo_q[DVW-1]} : trial[DVW-1:0];

	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[slot_wa] <= slot_wd;
		slot_rd_q <= slot_mem[slot_ra];
		if (list_we) list_mem[list_wa] <= list_wd;
		list_rd_q <= list_mem[list_ra];
	end

	always_comb begin
		slot_we = 1'b0;
		slot_wa = base + AW'(idx_q);
		slot_wd = val_q;
		slot_ra = base + AW'(idx_q);
		list_we = 1'b0;
		list_wa = lw_q[BW-1:0];
		list_wd = list_rd_q;
		list_ra = lr_q[BW-1:0];
		unique case (state_q)
			bhsrp_pkg::ST_CLEAR: begin
				slot_we = 1'b1;
				slot_wa = clr_q;
				slot_wd = '0;
			end
			bhsrp_pkg::ST_SCAN: begin
				// Insert writes the first empty slot it finds.
				if (act_q == bhsrp_pkg::ACT_INSERT && slot_rd_q == '0) slot_we = 1'b1;
				if (act_q == bhsrp_pkg::ACT_INSERT && slot_rd_q == '0 && idx_q == '0
						&& cnt_q < CW'(NUM_BUCKETS)) begin
					list_we = 1'b1;
					list_wa = cnt_q[BW-1:0];
					list_wd = bkt_q;
				end
			end
			bhsrp_pkg::ST_SHRD: slot_ra = base + AW'(idx_q) + AW'(1);
			bhsrp_pkg::ST_SHWR: begin
				slot_we = 1'b1;
				slot_wd = (idx_q == SCW'(BUCKET_SLOTS - 1)) ? '0 : slot_rd_q;
			end
			bhsrp_pkg::ST_LCMP: list_we = (list_rd_q != bkt_q);
			bhsrp_pkg::ST_PLRD: list_ra = rem_q[BW-1:0];
			bhsrp_pkg::ST_PSRD: slot_ra = AW'(list_rd_q) * AW'(BUCKET_SLOTS);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bhsrp_pkg::ST_CLEAR;
			clr_q    <= '0;
			cnt_q    <= '0;
			zero_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
			unique case (state_q)
				bhsrp_pkg::ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEP - 1)) state_q <= bhsrp_pkg::ST_IDLE;
				end
				bhsrp_pkg::ST_IDLE: begin
					if (in_valid && !in_stall) begin
						act_q  <= action;
						val_q  <= value;
						bkt_q  <= mag[BW-1:0];
						idx_q  <= '0;
						succ_q <= 1'b0;
						full_q <= 1'b0;
						pick_q <= '0;
						quo_q  <= (action == bhsrp_pkg::ACT_PICK) ? {1'b0, random_word} : mag;
						rem_q  <= '0;
						dbit_q <= '0;
						if (action == bhsrp_pkg::ACT_NONE) begin
							state_q <= bhsrp_pkg::ST_OUT;
						end else if (action == bhsrp_pkg::ACT_PICK) begin
							state_q <= (cnt_q == '0) ? bhsrp_pkg::ST_OUT : bhsrp_pkg::ST_DIV;
						end else if (value == '0) begin
							if (action == bhsrp_pkg::ACT_INSERT) begin
								succ_q <= !zero_q;
								zero_q <= 1'b1;
							end else begin
								succ_q <= zero_q;
								zero_q <= 1'b0;
							end
							state_q <= bhsrp_pkg::ST_OUT;
						end else if (BKT_POW2) begin
							state_q <= bhsrp_pkg::ST_SRD;
						end else begin
							state_q <= bhsrp_pkg::ST_DIV;
						end
					end
				end
				bhsrp_pkg::ST_SRD: state_q <= bhsrp_pkg::ST_SCAN;
				bhsrp_pkg::ST_SCAN: begin
					priority if (slot_rd_q == '0) begin
						if (act_q == bhsrp_pkg::ACT_INSERT) begin
							succ_q <= 1'b1;
							if (idx_q == '0 && cnt_q < CW'(NUM_BUCKETS)) cnt_q <= cnt_q + CW'(1);
						end
						state_q <= bhsrp_pkg::ST_OUT;
					end else if (slot_rd_q == val_q) begin
						if (act_q == bhsrp_pkg::ACT_REMOVE) begin
							succ_q  <= 1'b1;
							state_q <= bhsrp_pkg::ST_SHRD;
						end else begin
							state_q <= bhsrp_pkg::ST_OUT;
						end
					end else if (idx_q == SCW'(BUCKET_SLOTS - 1)) begin
						full_q  <= (act_q == bhsrp_pkg::ACT_INSERT);
						state_q <= bhsrp_pkg::ST_OUT;
					end else begin
						idx_q   <= idx_q + SCW'(1);
						state_q <= bhsrp_pkg::ST_SRD;
					end
				end
				bhsrp_pkg::ST_SHRD: state_q <= bhsrp_pkg::ST_SHWR;
				bhsrp_pkg::ST_SHWR: begin
					if (idx_q == SCW'(BUCKET_SLOTS - 1)) begin
						// Slot 0 now empty means the bucket left the list.
						idx_q   <= '0;
						state_q <= bhsrp_pkg::ST_LWT;
					end else begin
						idx_q   <= idx_q + SCW'(1);
						state_q <= bhsrp_pkg::ST_SHRD;
					end
				end
				bhsrp_pkg::ST_LWT: begin
					// Slot 0 is read again here after the shift settled.
					if (slot_rd_q == '0 && idx_q == SCW'(1)) begin
						lr_q    <= '0;
						lw_q    <= '0;
						state_q <= (cnt_q == '0) ? bhsrp_pkg::ST_OUT : bhsrp_pkg::ST_LRD;
					end else if (idx_q == SCW'(1)) begin
						state_q <= bhsrp_pkg::ST_OUT;
					end else begin
						idx_q <= SCW'(1);
					end
				end
				bhsrp_pkg::ST_LRD: state_q <= bhsrp_pkg::ST_LCMP;
				bhsrp_pkg::ST_LCMP: begin
					if (list_rd_q != bkt_q) lw_q <= lw_q + CW'(1);
					if (lr_q + CW'(1) == cnt_q) begin
						cnt_q   <= (list_rd_q != bkt_q) ? lw_q + CW'(1) : lw_q;
						state_q <= bhsrp_pkg::ST_OUT;
					end else begin
						lr_q    <= lr_q + CW'(1);
						state_q <= bhsrp_pkg::ST_LRD;
					end
				end
				bhsrp_pkg::ST_DIV: begin
					rem_q  <= rem_nx;
					quo_q  <= {quo_q[DVW-2:0], !trial[DVW]};
					dbit_q <= dbit_q + 5'd1;
					if (dbit_q == 5'(DVW - 1)) begin
						if (act_q == bhsrp_pkg::ACT_PICK) begin
							state_q <= bhsrp_pkg::ST_PLRD;
						end else begin
							bkt_q   <= rem_nx[BW-1:0];
							state_q <= bhsrp_pkg::ST_SRD;
						end
					end
				end
				bhsrp_pkg::ST_PLRD: state_q <= bhsrp_pkg::ST_PSRD;
				bhsrp_pkg::ST_PSRD: state_q <= bhsrp_pkg::ST_PSWT;
				bhsrp_pkg::ST_PSWT: begin
					pick_q  <= slot_rd_q;
					state_q <= bhsrp_pkg::ST_OUT;
				end
				bhsrp_pkg::ST_OUT: begin
					ovalid_q <= 1'b1;
					state_q  <= bhsrp_pkg::ST_IDLE;
				end
				default: state_q <= bhsrp_pkg::ST_IDLE;
			endcase
		end
	end

	// In ST_LWT slot 0 must be addressed: idx_q is 0 on entry, then 1 for check.
	// Read address uses base+idx_q, so slot 0 is read on entry and checked once idx_q is 1.

	a_one_state: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(NUM_BUCKETS)) else $error("list count overflow");
	a_out_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bhsrp_pkg::ST_OUT |=> ovalid_q) else $error("result not raised");
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q |-> !(succ_q && full_q)) else $error("success with full");

endmodule
